[src/trht_pkg.sv]
// Shared types and constants for the topmost region hit test block.
// Request/result payload structs, the region table entry and the FSM states.
// No dependencies.
package trht_pkg;

	localparam int COORD_BITS      = 16;
	localparam int RADIUS_BITS     = 20;
	localparam int SLOT_FIELD_BITS = 6;
	localparam int COUNT_BITS      = 7;
	localparam int DEF_SLOTS       = 64;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic                           kind;
		logic [SLOT_FIELD_BITS-1:0]     slot;
		logic                           shape_circle;
		logic                           control_menu;
		logic signed [COORD_BITS-1:0]   pos_x;
		logic signed [COORD_BITS-1:0]   pos_y;
		logic [COORD_BITS-1:0]          extent_w;
		logic [COORD_BITS-1:0]          extent_h;
		logic [RADIUS_BITS-1:0]         radius_q;
	} req_t;

	typedef struct packed {
		logic                       hit;
		logic [SLOT_FIELD_BITS-1:0] hit_slot;
		logic                       hit_menu;
	} rsp_t;

	typedef struct packed {
		logic                         circle;
		logic                         menu;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0]        w;
		logic [COORD_BITS-1:0]        h;
		logic [RADIUS_BITS-1:0]       radius;
	} entry_t;

	// pipeline tag for one table read in flight
	typedef struct packed {
		logic valid;   // slot read in flight
		logic last;    // slot 0, end of the scan
		logic live;    // slot was loaded
	} tag_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

[src/trht_region_test.sv]
// Two-stage containment test for one table entry against the query point.
// Stage 2: offsets and rectangle bounds; stage 3: squares; decision after stage 3.
// Depends on trht_pkg.
module trht_region_test #(
	parameter int SLOT_BITS = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  flush,
	input  trht_pkg::tag_t                        tag_s1,
	input  logic [SLOT_BITS-1:0]                  slot_s1,
	input  trht_pkg::entry_t                      ent_s1,
	input  logic signed [trht_pkg::COORD_BITS-1:0] px,
	input  logic signed [trht_pkg::COORD_BITS-1:0] py,
	output trht_pkg::tag_t                        tag_s3,
	output logic [SLOT_BITS-1:0]                  slot_s3,
	output logic                                  menu_s3,
	output logic                                  hit_s3
);

	localparam int DW   = trht_pkg::COORD_BITS + 1;
	localparam int PW   = 2 * DW;
	localparam int SUMW = PW + 1 + 8;
	localparam int R2W  = 2 * trht_pkg::RADIUS_BITS;
	localparam int CMPW = (SUMW > R2W) ? SUMW : R2W;

	logic signed [DW-1:0] dx, dy;
	logic                 rect_ok;

	logic signed [DW-1:0]                 dx_s2, dy_s2;
	logic [trht_pkg::RADIUS_BITS-1:0]     rad_s2;
	logic                                 circ_s2, rect_s2, menu_s2;
	logic [SLOT_BITS-1:0]                 slot_s2;
	trht_pkg::tag_t                       tag_s2;

	logic signed [PW-1:0] dx2, dy2;
	logic [PW-1:0]        dx2_s3, dy2_s3;
	logic [R2W-1:0]       r2_s3;
	logic                 circ_s3, rect_s3;

	logic [CMPW-1:0] d2_scaled;

	always_comb begin
		dx = $signed({px[trht_pkg::COORD_BITS-1], px})
			- $signed({ent_s1.x[trht_pkg::COORD_BITS-1], ent_s1.x});
		dy = $signed({py[trht_pkg::COORD_BITS-1], py})
			- $signed({ent_s1.y[trht_pkg::COORD_BITS-1], ent_s1.y});
		// offsets are nonnegative and within the inclusive extent
		rect_ok = !dx[DW-1] && !dy[DW-1]
			&& (unsigned'(dx) <= {1'b0, ent_s1.w})
			&& (unsigned'(dy) <= {1'b0, ent_s1.h});
	end

	always_comb begin
		dx2 = dx_s2 * dx_s2;
		dy2 = dy_s2 * dy_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (flush) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2   <= dx;
		dy_s2   <= dy;
		rad_s2  <= ent_s1.radius;
		circ_s2 <= ent_s1.circle;
		menu_s2 <= ent_s1.menu;
		rect_s2 <= rect_ok;
		slot_s2 <= slot_s1;

		dx2_s3  <= unsigned'(dx2);
		dy2_s3  <= unsigned'(dy2);
		r2_s3   <= R2W'(rad_s2) * R2W'(rad_s2);
		circ_s3 <= circ_s2;
		rect_s3 <= rect_s2;
		menu_s3 <= menu_s2;
		slot_s3 <= slot_s2;
	end

	// strict circle test: 256 * (dx^2 + dy^2) < r^2
	always_comb begin
		d2_scaled = CMPW'({(CMPW'(dx2_s3) + CMPW'(dy2_s3)), 8'h00});
		if (circ_s3) begin
			hit_s3 = tag_s3.live && (d2_scaled < CMPW'(r2_s3));
		end else begin
			hit_s3 = tag_s3.live && rect_s3;
		end
	end

endmodule

[src/topmost_region_hit_test.sv]
// Top level of the topmost region hit test: region table memory, scan control
// and result register. Depends on trht_pkg and trht_region_test.
//
// Usage:
//   Requests enter on req with start; one is taken at a clock edge where start
//   is high and busy is low. A load request (kind = 0) writes one table slot in
//   the cycle it is taken and gives no result; busy stays low, so loads can be
//   issued every cycle. Loads to a slot at or above SLOTS are dropped.
//   A query request (kind = 1) scans the table from slot min(region_count,
//   SLOTS) - 1 down to slot 0, one memory read per cycle, through a three-stage
//   read/test pipeline. The result appears on rsp with done high for one cycle.
//   A query that stops at a slot read gives done once that read has passed the
//   s1, s2 and s3 pipeline registers and the done register; a query with no
//   slots to scan gives done in the next cycle. The single table read port sets
//   the scan rate. busy is high from the cycle after a query is taken until the
//   cycle done is shown, so a new request can be taken while done is high.
//   The receiver cannot stall: done is a one-cycle strobe.
//   region_count is written on the cfg channel (cfg_ready is always high); the
//   user must write it only while no query is in flight, as the block does not enforce it.
//   Reset clears region_count, all slot valid bits and the scan control;
//   the table contents themselves are not cleared.
module topmost_region_hit_test #(
	parameter int SLOTS = trht_pkg::DEF_SLOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  trht_pkg::req_t                    req,
	output logic                              done,
	output trht_pkg::rsp_t                    rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [trht_pkg::COUNT_BITS-1:0]   cfg_data
);

	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CLOGN = $clog2(SLOTS + 1);
	localparam int CNTW  = (CLOGN > trht_pkg::COUNT_BITS) ? CLOGN : trht_pkg::COUNT_BITS;
	localparam int SW    = (CLOGN > trht_pkg::SLOT_FIELD_BITS) ? CLOGN
		: trht_pkg::SLOT_FIELD_BITS;

	trht_pkg::state_t state_q, state_d;

	logic [trht_pkg::COUNT_BITS-1:0] rc_q;
	logic                            vld_q [SLOTS];
	trht_pkg::entry_t                entry_mem [SLOTS];

	logic                                   issue_q;
	logic [IW-1:0]                          idx_q;
	logic signed [trht_pkg::COORD_BITS-1:0] px_q, py_q;

	trht_pkg::tag_t   tag_s1;
	logic [IW-1:0]    slot_s1;
	trht_pkg::entry_t rdata_s1;

	trht_pkg::tag_t tag_s3;
	logic [IW-1:0]  slot_s3;
	logic           menu_s3;
	logic           hit_s3;

	logic          done_q;
	trht_pkg::rsp_t rsp_q;

	logic             accept, query_go, empty_query, load_go, issue, flush;
	logic [CNTW-1:0]  n_scan;
	trht_pkg::entry_t wentry;

	always_comb begin
		busy        = (state_q == trht_pkg::ST_SCAN);
		accept      = start && !busy;
		n_scan      = (CNTW'(rc_q) > CNTW'(SLOTS)) ? CNTW'(SLOTS) : CNTW'(rc_q);
		query_go    = accept && (req.kind == trht_pkg::KIND_QUERY);
		empty_query = query_go && (n_scan == '0);
		load_go     = accept && (req.kind == trht_pkg::KIND_LOAD)
			&& (SW'(req.slot) < SW'(SLOTS));
		issue       = busy && issue_q;
		// scan ends at the first hit, or when the slot 0 read misses
		flush       = tag_s3.valid && (hit_s3 || tag_s3.last);

		state_d = state_q;
		unique case (state_q)
			trht_pkg::ST_IDLE: begin
				if (query_go && !empty_query) begin
					state_d = trht_pkg::ST_SCAN;
				end
			end
			trht_pkg::ST_SCAN: begin
				if (flush) begin
					state_d = trht_pkg::ST_IDLE;
				end
			end
			default: state_d = trht_pkg::ST_IDLE;
		endcase

		wentry.circle = req.shape_circle;
		wentry.menu   = req.control_menu;
		wentry.x      = req.pos_x;
		wentry.y      = req.pos_y;
		wentry.w      = req.extent_w;
		wentry.h      = req.extent_h;
		wentry.radius = req.radius_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trht_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			rc_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (load_go) begin
			vld_q[IW'(req.slot)] <= 1'b1;
		end
	end

	// table memory: one write port for loads, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (load_go) begin
			entry_mem[IW'(req.slot)] <= wentry;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= entry_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			idx_q   <= '0;
			tag_s1  <= '0;
		end else begin
			if (query_go && !empty_query) begin
				issue_q <= 1'b1;
				idx_q   <= IW'(n_scan - CNTW'(1));
			end else if (flush) begin
				issue_q <= 1'b0;
			end else if (issue) begin
				issue_q <= (idx_q != '0);
				idx_q   <= idx_q - IW'(1);
			end

			if (issue && !flush) begin
				tag_s1.valid <= 1'b1;
				tag_s1.last  <= (idx_q == '0);
				tag_s1.live  <= vld_q[idx_q];
			end else begin
				tag_s1 <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_go) begin
			px_q <= req.pos_x;
			py_q <= req.pos_y;
		end
		slot_s1 <= idx_q;
	end

	trht_region_test #(
		.SLOT_BITS(IW)
	) u_test (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (flush),
		.tag_s1 (tag_s1),
		.slot_s1(slot_s1),
		.ent_s1 (rdata_s1),
		.px     (px_q),
		.py     (py_q),
		.tag_s3 (tag_s3),
		.slot_s3(slot_s3),
		.menu_s3(menu_s3),
		.hit_s3 (hit_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= empty_query || flush;
		end
	end

	always_ff @(posedge clk) begin
		if (flush && hit_s3) begin
			rsp_q.hit      <= 1'b1;
			rsp_q.hit_slot <= trht_pkg::SLOT_FIELD_BITS'(slot_s3);
			rsp_q.hit_menu <= menu_s3;
		end else if (flush || empty_query) begin
			rsp_q <= '0;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
